@@ hdl/go_to_point_pi_controller_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Go-to-point controller assertion macros
// Shared property templates clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GO_TO_POINT_PI_CONTROLLER_UNIT_ASSERT_SVH
`define GO_TO_POINT_PI_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define GPC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define GPC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/gpc_pkg.sv @@
// ----------------------------------------------------------------------------
// gpc_pkg
// Types, constants and helper functions of the go-to-point controller.
// ----------------------------------------------------------------------------
package gpc_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int STEPS        = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
  localparam int STEP_W       = $clog2(TABLE_LEN);
  localparam int MOD_STEPS    = 30 - FRAC_BITS;
  localparam int K_W          = $clog2(MOD_STEPS);
  localparam int ZM_W         = 63 - FRAC_BITS;
  localparam int MAG_PRE      = 8;
  localparam int MAG_SH       = 16 + MAG_PRE;

  localparam int ANG_W = 35;
  localparam int MAG_W = 44;
  localparam int MB_W  = 26;
  localparam int P_W   = MAG_W + MB_W;
  localparam int BIG_W = P_W + 2;
  localparam int ERR_W = 36;
  localparam int INT_W = 38;
  localparam int ROB_W = 36;
  localparam int U_W   = 26;

  localparam int NUM_REGS = 4;
  localparam int ADDR_W   = $clog2(NUM_REGS) + 2;

  localparam logic [1:0] REG_DIST_GAIN  = 2'd0;
  localparam logic [1:0] REG_HEAD_GAIN  = 2'd1;
  localparam logic [1:0] REG_INT_RATE   = 2'd2;
  localparam logic [1:0] REG_DRIVE_LIM  = 2'd3;

  localparam logic [23:0] DIST_GAIN_RST = 24'(64'd50 << FRAC_BITS);
  localparam logic [23:0] HEAD_GAIN_RST = 24'(64'd30 << FRAC_BITS);
  localparam logic [16:0] INT_RATE_RST  = 17'(((64'd1 << (FRAC_BITS + 1)) + 64'd1) / 3);
  localparam logic [23:0] DRIVE_LIM_RST = 24'(64'd100 << FRAC_BITS);
  localparam logic signed [31:0] ISUM_RST = 32'((64'd1 << FRAC_BITS) / 100);

  localparam logic signed [ANG_W-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 35'sd6746518852;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic [ZM_W-1:0]         TWO_PI_ZM   = ZM_W'(64'd6746518852);
  localparam logic signed [MAG_W-1:0] KINV_Q30    = 44'sd652032875;
  localparam logic signed [MB_W-1:0]  KINV_Q16    = 26'sd39797;

  localparam logic signed [BIG_W-1:0] HALF_F  = BIG_W'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [BIG_W-1:0] HALF_24 = BIG_W'(64'd1 << 23);
  localparam logic signed [BIG_W-1:0] HALF_MG = BIG_W'(64'd1 << (MAG_SH - 1));

  localparam logic signed [ANG_W-1:0] ATAN_Q30 [TABLE_LEN] = '{
    35'sd843314856, 35'sd497837829, 35'sd263043836, 35'sd133525158,
    35'sd67021686,  35'sd33543515,  35'sd16775850,  35'sd8388437,
    35'sd4194282,   35'sd2097149,   35'sd1048575,   35'sd524287,
    35'sd262143,    35'sd131071,    35'sd65535,     35'sd32767,
    35'sd16383,     35'sd8191,      35'sd4095,      35'sd2047,
    35'sd1023,      35'sd511,       35'sd255,       35'sd127
  };

  typedef struct packed {
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_heading;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [31:0] pose_heading;
  } gpc_in_t;

  typedef struct packed {
    logic signed [31:0] drive_first;
    logic signed [31:0] drive_second;
    logic signed [31:0] turn_rate;
    logic               saturated;
  } gpc_out_t;

  typedef struct packed {
    logic [23:0] distance_gain;
    logic [23:0] heading_gain;
    logic [16:0] integral_rate;
    logic [23:0] drive_limit;
  } gpc_cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [BIG_W-1:0] v);
    logic signed [BIG_W-1:0] hi;
    logic signed [BIG_W-1:0] lo;
    hi = BIG_W'(64'sd2147483647);
    lo = BIG_W'(-64'sd2147483648);
    if (v > hi) begin
      return 32'sh7FFFFFFF;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return 32'(v);
  endfunction

  function automatic logic signed [BIG_W-1:0] clamp_sym(input logic signed [BIG_W-1:0] v,
                                                        input logic signed [BIG_W-1:0] lim);
    if (v > lim) begin
      return lim;
    end else if (v < -lim) begin
      return -lim;
    end
    return v;
  endfunction

endpackage

@@ hdl/gpc_regs.sv @@
// ----------------------------------------------------------------------------
// gpc_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module gpc_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [gpc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output gpc_pkg::gpc_cfg_t         cfg
);
  import gpc_pkg::*;

  gpc_cfg_t   cfg_r;
  gpc_cfg_t   cfg_nxt;
  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[ADDR_W-1:2];
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_DIST_GAIN: cfg_nxt.distance_gain = pwdata[23:0];
        REG_HEAD_GAIN: cfg_nxt.heading_gain  = pwdata[23:0];
        REG_INT_RATE:  cfg_nxt.integral_rate = pwdata[16:0];
        REG_DRIVE_LIM: cfg_nxt.drive_limit   = pwdata[23:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DIST_GAIN: prdata = {8'd0, cfg_r.distance_gain};
      REG_HEAD_GAIN: prdata = {8'd0, cfg_r.heading_gain};
      REG_INT_RATE:  prdata = {15'd0, cfg_r.integral_rate};
      REG_DRIVE_LIM: prdata = {8'd0, cfg_r.drive_limit};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.distance_gain <= DIST_GAIN_RST;
      cfg_r.heading_gain  <= HEAD_GAIN_RST;
      cfg_r.integral_rate <= INT_RATE_RST;
      cfg_r.drive_limit   <= DRIVE_LIM_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ hdl/go_to_point_pi_controller_unit.sv @@
// ----------------------------------------------------------------------------
// go_to_point_pi_controller_unit
// Go-to-point PI controller: distance loop with anti-windup, heading loop,
// CORDIC length and sine/cosine, all on one shared multiplier.
// ----------------------------------------------------------------------------
// in_stall is high while a request is in work; a result waits in the output
// register and the next request is taken meanwhile.
// Reset clears the sequencer and output valid, and sets the integral (0.01)
// and config to their defaults.
module go_to_point_pi_controller_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  gpc_pkg::gpc_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output gpc_pkg::gpc_out_t          out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gpc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import gpc_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_MAG    = 5'd1;
  localparam logic [4:0] S_MAGMUL = 5'd2;
  localparam logic [4:0] S_ERR    = 5'd3;
  localparam logic [4:0] S_RMUL   = 5'd4;
  localparam logic [4:0] S_INTEG  = 5'd5;
  localparam logic [4:0] S_GMUL   = 5'd6;
  localparam logic [4:0] S_VCLAMP = 5'd7;
  localparam logic [4:0] S_HMUL   = 5'd8;
  localparam logic [4:0] S_WCLAMP = 5'd9;
  localparam logic [4:0] S_MOD    = 5'd10;
  localparam logic [4:0] S_FOLD   = 5'd11;
  localparam logic [4:0] S_ROT    = 5'd12;
  localparam logic [4:0] S_RND    = 5'd13;
  localparam logic [4:0] S_M1     = 5'd14;
  localparam logic [4:0] S_M2     = 5'd15;
  localparam logic [4:0] S_M3     = 5'd16;
  localparam logic [4:0] S_M4     = 5'd17;
  localparam logic [4:0] S_M5     = 5'd18;
  localparam logic [4:0] S_M6     = 5'd19;
  localparam logic [4:0] S_DONE   = 5'd20;

  gpc_cfg_t cfg;

  logic [4:0]               state_r,  state_nxt;
  logic [STEP_W-1:0]        i_r,      i_nxt;
  logic [K_W-1:0]           k_r,      k_nxt;
  logic signed [32:0]       rx_r,     rx_nxt;
  logic signed [32:0]       ry_r,     ry_nxt;
  logic signed [32:0]       dh_r,     dh_nxt;
  logic signed [MAG_W-1:0]  x_r,      x_nxt;
  logic signed [MAG_W-1:0]  y_r,      y_nxt;
  logic [ZM_W-1:0]          zm_r,     zm_nxt;
  logic                     zneg_r,   zneg_nxt;
  logic signed [ANG_W-1:0]  z_r,      z_nxt;
  logic                     neg_r,    neg_nxt;
  logic signed [P_W-1:0]    prod_r,   prod_nxt;
  logic signed [P_W-1:0]    acc_r,    acc_nxt;
  logic signed [ERR_W-1:0]  err_r,    err_nxt;
  logic signed [INT_W-1:0]  integ_r,  integ_nxt;
  logic signed [31:0]       isum_r,   isum_nxt;
  logic signed [U_W-1:0]    u_r,      u_nxt;
  logic signed [U_W-1:0]    w_r,      w_nxt;
  logic                     sat_r,    sat_nxt;
  logic signed [MB_W-1:0]   c24_r,    c24_nxt;
  logic signed [MB_W-1:0]   s24_r,    s24_nxt;
  logic signed [ROB_W-1:0]  robx_r,   robx_nxt;
  logic signed [ROB_W-1:0]  roby_r,   roby_nxt;
  logic signed [31:0]       dsec_r,   dsec_nxt;
  logic                     ovld_r,   ovld_nxt;
  gpc_out_t                 odata_r,  odata_nxt;

  logic                     in_acc;
  logic                     out_free;
  logic signed [MAG_W-1:0]  mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [P_W-1:0]    mul_p;
  logic                     mul_en;
  logic signed [BIG_W-1:0]  prod_ext;
  logic signed [BIG_W-1:0]  rnd_f;
  logic signed [BIG_W-1:0]  rnd_mag;
  logic signed [BIG_W-1:0]  lim_ext;
  logic signed [INT_W:0]    ei_sum;
  logic signed [MAG_W-1:0]  dx;
  logic signed [MAG_W-1:0]  dy;
  logic signed [33:0]       rx_in;
  logic signed [33:0]       rx_abs;
  logic signed [32:0]       ph_abs;
  logic [ZM_W-1:0]          tp_sh;
  logic signed [ANG_W-1:0]  zs;
  logic signed [MAG_W-1:0]  cs_x;
  logic signed [MAG_W-1:0]  cs_y;
  logic signed [BIG_W-1:0]  v_val;
  logic                     v_sat;

  gpc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid & ~in_stall;
  assign out_valid = ovld_r;
  assign out_data  = odata_r;
  assign out_free  = ~ovld_r | ~out_stall;

  assign mul_p    = mul_a * mul_b;
  assign prod_ext = BIG_W'(prod_r);
  assign rnd_f    = (prod_ext + HALF_F) >>> FRAC_BITS;
  assign rnd_mag  = (prod_ext + HALF_MG) >>> MAG_SH;
  assign lim_ext  = BIG_W'($signed({1'b0, cfg.drive_limit}));
  assign ei_sum   = (INT_W + 1)'(err_r) + (INT_W + 1)'(integ_r);
  assign dx       = y_r >>> i_r;
  assign dy       = x_r >>> i_r;
  assign rx_in    = 34'(in_data.target_x) - 34'(in_data.pose_x);
  assign rx_abs   = (rx_in < 0) ? -rx_in : rx_in;
  assign ph_abs   = (in_data.pose_heading < 0) ? -33'(in_data.pose_heading)
                                               : 33'(in_data.pose_heading);
  assign tp_sh    = TWO_PI_ZM << k_r;
  assign zs       = zneg_r ? -$signed(ANG_W'(zm_r)) : $signed(ANG_W'(zm_r));
  assign cs_x     = neg_r ? -x_r : x_r;
  assign cs_y     = neg_r ? -y_r : y_r;
  assign v_val    = rnd_f;
  assign v_sat    = (v_val > lim_ext) || (v_val < -lim_ext);

  always_comb begin
    mul_en = 1'b1;
    unique case (state_r)
      S_MAGMUL: begin
        mul_a = x_r;
        mul_b = KINV_Q16;
      end
      S_RMUL: begin
        mul_a = MAG_W'(err_r);
        mul_b = MB_W'($signed({1'b0, cfg.integral_rate}));
      end
      S_GMUL: begin
        mul_a = MAG_W'(ei_sum);
        mul_b = MB_W'($signed({1'b0, cfg.distance_gain}));
      end
      S_HMUL: begin
        mul_a = MAG_W'(dh_r);
        mul_b = MB_W'($signed({1'b0, cfg.heading_gain}));
      end
      S_M1: begin
        mul_a = MAG_W'(rx_r);
        mul_b = c24_r;
      end
      S_M2: begin
        mul_a = MAG_W'(ry_r);
        mul_b = s24_r;
      end
      S_M3: begin
        mul_a = MAG_W'(rx_r);
        mul_b = s24_r;
      end
      S_M4: begin
        mul_a = MAG_W'(ry_r);
        mul_b = c24_r;
      end
      S_M5: begin
        mul_a = MAG_W'(robx_r);
        mul_b = MB_W'(u_r);
      end
      S_M6: begin
        mul_a = MAG_W'(roby_r);
        mul_b = MB_W'(u_r);
      end
      default: begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    rx_nxt    = rx_r;
    ry_nxt    = ry_r;
    dh_nxt    = dh_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    zm_nxt    = zm_r;
    zneg_nxt  = zneg_r;
    z_nxt     = z_r;
    neg_nxt   = neg_r;
    prod_nxt  = mul_en ? mul_p : prod_r;
    acc_nxt   = acc_r;
    err_nxt   = err_r;
    integ_nxt = integ_r;
    isum_nxt  = isum_r;
    u_nxt     = u_r;
    w_nxt     = w_r;
    sat_nxt   = sat_r;
    c24_nxt   = c24_r;
    s24_nxt   = s24_r;
    robx_nxt  = robx_r;
    roby_nxt  = roby_r;
    dsec_nxt  = dsec_r;
    ovld_nxt  = ovld_r & out_stall;
    odata_nxt = odata_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          rx_nxt    = 33'(rx_in);
          ry_nxt    = 33'(in_data.target_y) - 33'(in_data.pose_y);
          dh_nxt    = 33'(in_data.target_heading) - 33'(in_data.pose_heading);
          x_nxt     = MAG_W'(rx_abs) <<< MAG_PRE;
          y_nxt     = MAG_W'(33'(in_data.target_y) - 33'(in_data.pose_y)) <<< MAG_PRE;
          zm_nxt    = ZM_W'($unsigned(ph_abs)) << (30 - FRAC_BITS);
          zneg_nxt  = (in_data.pose_heading > 0);
          k_nxt     = K_W'(MOD_STEPS - 1);
          i_nxt     = '0;
          state_nxt = S_MAG;
        end
      end
      S_MAG: begin
        if (y_r > 0) begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
        end else begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
        end
        i_nxt = i_r + 1'b1;
        if (i_r == STEP_W'(STEPS - 1)) begin
          state_nxt = S_MAGMUL;
        end
      end
      S_MAGMUL: state_nxt = S_ERR;
      S_ERR: begin
        err_nxt   = ERR_W'(-rnd_mag);
        state_nxt = S_RMUL;
      end
      S_RMUL: state_nxt = S_INTEG;
      S_INTEG: begin
        integ_nxt = INT_W'(BIG_W'(isum_r) + rnd_f);
        state_nxt = S_GMUL;
      end
      S_GMUL: state_nxt = S_VCLAMP;
      S_VCLAMP: begin
        sat_nxt   = v_sat;
        u_nxt     = U_W'(clamp_sym(v_val, lim_ext));
        isum_nxt  = v_sat ? isum_r : sat32(BIG_W'(integ_r));
        state_nxt = S_HMUL;
      end
      S_HMUL: state_nxt = S_WCLAMP;
      S_WCLAMP: begin
        w_nxt     = U_W'(clamp_sym(rnd_f, lim_ext));
        state_nxt = S_MOD;
      end
      S_MOD: begin
        if (zm_r >= tp_sh) begin
          zm_nxt = zm_r - tp_sh;
        end
        k_nxt = k_r - 1'b1;
        if (k_r == '0) begin
          state_nxt = S_FOLD;
        end
      end
      S_FOLD: begin
        z_nxt   = zs;
        neg_nxt = 1'b0;
        if (zs > PI_Q30) begin
          z_nxt = zs - TWO_PI_Q30;
        end else if (zs < -PI_Q30) begin
          z_nxt = zs + TWO_PI_Q30;
        end
        if (z_nxt > HALF_PI_Q30) begin
          z_nxt   = z_nxt - PI_Q30;
          neg_nxt = 1'b1;
        end else if (z_nxt < -HALF_PI_Q30) begin
          z_nxt   = z_nxt + PI_Q30;
          neg_nxt = 1'b1;
        end
        x_nxt     = KINV_Q30;
        y_nxt     = '0;
        i_nxt     = '0;
        state_nxt = S_ROT;
      end
      S_ROT: begin
        if (z_r >= 0) begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          z_nxt = z_r - ATAN_Q30[i_r];
        end else begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          z_nxt = z_r + ATAN_Q30[i_r];
        end
        i_nxt = i_r + 1'b1;
        if (i_r == STEP_W'(STEPS - 1)) begin
          state_nxt = S_RND;
        end
      end
      S_RND: begin
        c24_nxt   = MB_W'((cs_x + MAG_W'(32)) >>> 6);
        s24_nxt   = MB_W'((cs_y + MAG_W'(32)) >>> 6);
        state_nxt = S_M1;
      end
      S_M1: state_nxt = S_M2;
      S_M2: begin
        acc_nxt   = prod_r;
        state_nxt = S_M3;
      end
      S_M3: begin
        robx_nxt  = ROB_W'((BIG_W'(acc_r) - prod_ext + HALF_24) >>> 24);
        state_nxt = S_M4;
      end
      S_M4: begin
        acc_nxt   = prod_r;
        state_nxt = S_M5;
      end
      S_M5: begin
        roby_nxt  = ROB_W'((BIG_W'(acc_r) + prod_ext + HALF_24) >>> 24);
        state_nxt = S_M6;
      end
      S_M6: begin
        dsec_nxt  = sat32(-rnd_f);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          odata_nxt.drive_first  = sat32(-rnd_f);
          odata_nxt.drive_second = dsec_r;
          odata_nxt.turn_rate    = 32'(w_r);
          odata_nxt.saturated    = sat_r;
          ovld_nxt               = 1'b1;
          state_nxt              = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovld_r  <= 1'b0;
      isum_r  <= ISUM_RST;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
      isum_r  <= isum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r     <= i_nxt;
    k_r     <= k_nxt;
    rx_r    <= rx_nxt;
    ry_r    <= ry_nxt;
    dh_r    <= dh_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    zm_r    <= zm_nxt;
    zneg_r  <= zneg_nxt;
    z_r     <= z_nxt;
    neg_r   <= neg_nxt;
    prod_r  <= prod_nxt;
    acc_r   <= acc_nxt;
    err_r   <= err_nxt;
    integ_r <= integ_nxt;
    u_r     <= u_nxt;
    w_r     <= w_nxt;
    sat_r   <= sat_nxt;
    c24_r   <= c24_nxt;
    s24_r   <= s24_nxt;
    robx_r  <= robx_nxt;
    roby_r  <= roby_nxt;
    dsec_r  <= dsec_nxt;
    odata_r <= odata_nxt;
  end

endmodule

@@ hdl/gpc_checker.sv @@
// ----------------------------------------------------------------------------
// gpc_checker
// Port-level checks of the go-to-point controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "go_to_point_pi_controller_unit_assert.svh"

module gpc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input gpc_pkg::gpc_out_t          out_data
);

  `GPC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `GPC_ASSERT_NXT(a_busy_after_req, in_valid && !in_stall, in_stall)
  `GPC_ASSERT_NXT(a_no_instant_result, in_valid && !in_stall, !$rose(out_valid))

endmodule

bind go_to_point_pi_controller_unit gpc_checker u_gpc_checker (.*);

@@ dv/tb_go_to_point_pi_controller_unit.sv @@
// ----------------------------------------------------------------------------
// Go-to-point PI controller testbench
// Drives pose and target requests through the valid/stall channel, predicts
// each result with a bit-accurate model of the distance and heading loops,
// and compares every result field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_go_to_point_pi_controller_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import gpc_pkg::*;

  class ctrl_scoreboard;
    longint dist_gain, head_gain, int_rate, drv_lim, isum;
    gpc_out_t pending_q[$];
    int errors;

    function new();
      dist_gain = DIST_GAIN_RST;
      head_gain = HEAD_GAIN_RST;
      int_rate = INT_RATE_RST;
      drv_lim = DRIVE_LIM_RST;
      isum = ISUM_RST;
      errors = 0;
    endfunction

    function longint shr(longint v, int s);
      return v >>> s;
    endfunction

    function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint qmul(longint a, longint b);
      return shr(a * b + (64'sd1 << (FRAC_BITS - 1)), FRAC_BITS);
    endfunction

    function longint lim_sym(longint v, longint l);
      if (v > l) return l;
      if (v < -l) return -l;
      return v;
    endfunction

    function longint length_of(longint rx, longint ry);
      longint x, y, dx, dy;
      x = (rx < 0 ? -rx : rx) * 256;
      y = ry * 256;
      for (int i = 0; i < STEPS; i++) begin
        dx = shr(y, i);
        dy = shr(x, i);
        if (y > 0) begin
          x += dx; y -= dy;
        end else begin
          x -= dx; y += dy;
        end
      end
      return shr(x * 39797 + (64'sd1 << 23), 24);
    endfunction

    function void rotate(longint a, output longint c, output longint s);
      longint z, x, y, dx, dy;
      bit flip;
      z = (a * (64'sd1 << (30 - FRAC_BITS))) % 64'sd6746518852;
      flip = 0;
      if (z > 64'sd3373259426) z -= 64'sd6746518852;
      if (z < -64'sd3373259426) z += 64'sd6746518852;
      if (z > 64'sd1686629713) begin
        z -= 64'sd3373259426; flip = 1;
      end else if (z < -64'sd1686629713) begin
        z += 64'sd3373259426; flip = 1;
      end
      x = 64'sd652032875;
      y = 0;
      for (int i = 0; i < STEPS; i++) begin
        dx = shr(y, i);
        dy = shr(x, i);
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
        end else begin
          x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function void set_reg(int idx, longint val);
      case (idx)
        REG_DIST_GAIN: dist_gain = val & 24'hFFFFFF;
        REG_HEAD_GAIN: head_gain = val & 24'hFFFFFF;
        REG_INT_RATE: int_rate = val & 17'h1FFFF;
        REG_DRIVE_LIM: drv_lim = val & 24'hFFFFFF;
        default: ;
      endcase
    endfunction

    function void note_request(gpc_in_t r);
      longint rx, ry, err, integ, v, u, w, c30, s30, c24, s24, bx, by;
      bit clip;
      gpc_out_t o;
      rx = longint'(r.target_x) - longint'(r.pose_x);
      ry = longint'(r.target_y) - longint'(r.pose_y);
      err = -length_of(rx, ry);
      integ = isum + qmul(int_rate, err);
      v = qmul(dist_gain, err + integ);
      clip = (v > drv_lim) || (v < -drv_lim);
      if (clip) integ = isum;
      u = lim_sym(v, drv_lim);
      isum = sat(integ);
      w = lim_sym(qmul(head_gain, longint'(r.target_heading) - longint'(r.pose_heading)),
                  drv_lim);
      rotate(-longint'(r.pose_heading), c30, s30);
      c24 = shr(c30 + 32, 6);
      s24 = shr(s30 + 32, 6);
      bx = shr(rx * c24 - ry * s24 + (64'sd1 << 23), 24);
      by = shr(rx * s24 + ry * c24 + (64'sd1 << 23), 24);
      o.drive_first = 32'(sat(-qmul(u, by)));
      o.drive_second = 32'(sat(-qmul(u, bx)));
      o.turn_rate = 32'(sat(w));
      o.saturated = clip;
      pending_q.push_back(o);
    endfunction

    function void report(string what, longint got, longint want);
      errors++;
      $display("MISMATCH %s got %0d want %0d", what, got, want);
    endfunction

    function void check_result(gpc_out_t got);
      gpc_out_t exp_o;
      if (pending_q.size() == 0) begin
        report("result with no request pending", 0, 0);
        return;
      end
      exp_o = pending_q.pop_front();
      if (got.drive_first !== exp_o.drive_first)
        report("drive_first", got.drive_first, exp_o.drive_first);
      if (got.drive_second !== exp_o.drive_second)
        report("drive_second", got.drive_second, exp_o.drive_second);
      if (got.turn_rate !== exp_o.turn_rate)
        report("turn_rate", got.turn_rate, exp_o.turn_rate);
      if (got.saturated !== exp_o.saturated)
        report("saturated", got.saturated, exp_o.saturated);
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  gpc_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  gpc_out_t out_data;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ctrl_scoreboard sb = new();
  int send_idle = 12, recv_idle = 70;
  bit hold_recv = 0;

  go_to_point_pi_controller_unit dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (hold_recv) out_stall <= 1;
    else out_stall <= ($urandom_range(99) < recv_idle);
  end

  task automatic write_reg(int idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= ADDR_W'(idx * 4); pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.set_reg(idx, val);
  endtask

  task automatic send_request(gpc_in_t r);
    while ($urandom_range(99) < send_idle) begin
      @(posedge clk);
      in_valid <= 0;
    end
    @(posedge clk);
    in_valid <= 1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
    in_valid <= 0;
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_word(int kind);
    case (kind)
      0: return $urandom();
      1: return 32'($signed($urandom_range(2000000)) - 1000000);
      2: return 32'($signed($urandom_range(1200000)) - 600000);
      default: return 32'($signed($urandom_range(100000)) - 50000);
    endcase
  endfunction

  function automatic gpc_in_t rnd_request();
    gpc_in_t r;
    int k;
    k = $urandom_range(9) < 2 ? 0 : $urandom_range(3, 1);
    r.target_x = rnd_word(k);
    r.target_y = rnd_word(k);
    r.target_heading = rnd_word(k == 0 ? 0 : 2);
    r.pose_x = rnd_word(k);
    r.pose_y = rnd_word(k);
    r.pose_heading = rnd_word(k == 0 ? 0 : 2);
    return r;
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) send_request(rnd_request());
    drain();
  endtask

  initial begin
    logic [31:0] ext[6];
    gpc_in_t r;
    ext = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'hFFFFFFFF, 32'h00010000, 32'hFFFF0000};
    repeat (11) @(posedge clk);
    rst_n <= 1;
    for (int i = 0; i < 12; i++) begin
      r = {ext[i % 6], ext[(i + 1) % 6], ext[(i + 2) % 6],
           ext[(i + 3) % 6], ext[(i + 4) % 6], ext[(i + 5) % 6]};
      send_request(r);
    end
    r = '0;
    send_request(r);
    r.target_x = 32'sd655360; r.pose_heading = 32'sd205887;
    send_request(r);
    r.pose_heading = 32'sd411775; r.target_heading = -32'sd411775;
    send_request(r);
    drain();
    write_reg(REG_DRIVE_LIM, 0);
    send_request(rnd_request());
    send_request(rnd_request());
    drain();
    write_reg(REG_DIST_GAIN, 24'hFFFFFF);
    write_reg(REG_HEAD_GAIN, 24'hFFFFFF);
    write_reg(REG_INT_RATE, 32'h1FFFF);
    write_reg(REG_DRIVE_LIM, 24'hFFFFFF);
    random_phase(60);
    write_reg(REG_DIST_GAIN, 0);
    write_reg(REG_HEAD_GAIN, 0);
    write_reg(REG_INT_RATE, 0);
    write_reg(REG_DRIVE_LIM, 32'hFFFFFFFF);
    random_phase(40);
    write_reg(REG_DIST_GAIN, DIST_GAIN_RST);
    write_reg(REG_HEAD_GAIN, HEAD_GAIN_RST);
    write_reg(REG_INT_RATE, 32'h10000);
    write_reg(REG_DRIVE_LIM, DRIVE_LIM_RST);
    random_phase(200);
    send_idle = 70; recv_idle = 12;
    fork
      begin
        hold_recv = 1;
        repeat (600) @(posedge clk);
        hold_recv = 0;
      end
      for (int i = 0; i < 8; i++) send_request(rnd_request());
    join
    random_phase(200);
    send_idle = 0; recv_idle = 0;
    write_reg(REG_DIST_GAIN, 32'h00008000);
    write_reg(REG_INT_RATE, 32'h00004000);
    random_phase(230);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
